// ===== sv/rbd_pkg.sv =====
// ----------------------------------------------------------------------------
// rbd_pkg: shared types and codes for the ring buffer deque
// Item structs, operation and status codes, controller command bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package rbd_pkg;

	localparam int unsigned OP_W    = 3;
	localparam int unsigned DATA_W  = 32;
	localparam int unsigned STAT_W  = 2;
	localparam int unsigned CAP_W   = 5;

	// Operation codes
	localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
	localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
	localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
	localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
	localparam logic [OP_W-1:0] OP_PEEK_FRONT = 3'd4;
	localparam logic [OP_W-1:0] OP_PEEK_BACK  = 3'd5;

	// Status codes
	localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd2;
	localparam logic [STAT_W-1:0] ST_BAD_OP = 2'd3;

	// Capacity register value after reset
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	typedef struct packed {
		logic [OP_W-1:0]          op;
		logic signed [DATA_W-1:0] push_value;
	} in_item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] read_value;
		logic [STAT_W-1:0]        status;
		logic [CAP_W-1:0]         item_count;
	} out_item_t;

	// Controller to datapath commands
	typedef struct packed {
		logic exec;   // item accepted: run the operation
		logic emit;   // load the result register
	} rbd_cmd_t;

endpackage : rbd_pkg

`default_nettype wire

// ===== sv/ring_buffer_deque.sv =====
// ----------------------------------------------------------------------------
// ring_buffer_deque: double-ended queue in a circular store
// Push, pop and peek at either end; every item returns status and count.
// ----------------------------------------------------------------------------
//
//   channel | signals                          | moves
//   --------+----------------------------------+------------------------------
//   in      | in_valid / in_ready / in_item    | op + push_value, one item
//   out     | out_valid / out_ready / out_item | read_value, status, count
//   cfg     | cfg_we / cfg_wdata               | capacity_in_use, no wait
//
// Each item passes through the accept state and the response state: the
// accept cycle runs the operation against the entry memory (one write or one
// registered read), then the response state loads the result register once
// the output is free. The single memory port and its registered read set this
// sequence. The next item is taken as soon as the result is loaded, even while
// that result waits on out_ready; a stalled output holds the current item in
// the response state. Reset empties the queue and sets capacity to 16; memory
// contents are not cleared (only live entries are ever read). A capacity write
// empties the queue; 0 acts as 1, above DEPTH as DEPTH.
`default_nettype none

module ring_buffer_deque
	import rbd_pkg::*;
#(
	parameter int unsigned DEPTH = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,

	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire in_item_t         in_item,

	output logic                  out_valid,
	input  wire logic             out_ready,
	output out_item_t             out_item,

	input  wire logic             cfg_we,
	input  wire logic [CAP_W-1:0] cfg_wdata
);

	rbd_cmd_t cmd;

	// Sequencer: accept, then present the result
	rbd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// Store, pointers and result register
	rbd_dpath #(
		.DEPTH (DEPTH)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_item   (in_item),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.out_item  (out_item)
	);

endmodule : ring_buffer_deque

`default_nettype wire

// ===== sv/rbd_ctrl.sv =====
// ----------------------------------------------------------------------------
// rbd_ctrl: ring buffer deque controller
// Two-state sequencer: take an item, then hand its result to the output.
// ----------------------------------------------------------------------------
`default_nettype none

module rbd_ctrl
	import rbd_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  wire logic     out_ready,
	output rbd_cmd_t      cmd
);

	typedef enum logic {
		S_IDLE,
		S_RESP
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	assign cmd.exec = in_valid && (state_q == S_IDLE);
	assign cmd.emit = (state_q == S_RESP) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd.exec) begin
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					if (cmd.emit) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// One item in flight: nothing new enters until its result is loaded
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> !in_ready)
		else $error("rbd_ctrl: item taken while another is in flight");

	// A new result appears only out of the response state
	a_result_from_resp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == S_RESP))
		else $error("rbd_ctrl: result raised outside response state");

	// A waiting result stays valid until it is taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("rbd_ctrl: result dropped before it was taken");

endmodule : rbd_ctrl

`default_nettype wire

// ===== sv/rbd_dpath.sv =====
// ----------------------------------------------------------------------------
// rbd_dpath: ring buffer deque datapath
// Entry memory, front pointer, item count, capacity register, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rbd_dpath
	import rbd_pkg::*;
#(
	parameter int unsigned DEPTH = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire rbd_cmd_t         cmd,
	input  wire in_item_t         in_item,
	input  wire logic             cfg_we,
	input  wire logic [CAP_W-1:0] cfg_wdata,
	output out_item_t             out_item
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	// Arithmetic width: holds pointer + offset without overflow
	localparam int unsigned SW = ((PW > CAP_W) ? PW : CAP_W) + 1;

	logic [DATA_W-1:0] mem [DEPTH];

	logic [PW-1:0]     fp_q;
	logic [CAP_W-1:0]  cnt_q;
	logic [CAP_W-1:0]  cap_q;

	logic [DATA_W-1:0] rdata_q;
	logic              rd_sel_q;
	logic [STAT_W-1:0] stat_q;
	logic [CAP_W-1:0]  cnt_res_q;
	out_item_t         out_q;

	logic [CAP_W-1:0]  cap_eff;
	logic [SW-1:0]     cap_w;
	logic [SW-1:0]     fp_w;
	logic [CAP_W-1:0]  offs;
	logic [SW-1:0]     sum_w;
	logic [SW-1:0]     slot_w;
	logic [SW-1:0]     fp_inc_w;
	logic [PW-1:0]     slot_ptr;
	logic [PW-1:0]     fp_dec;
	logic [PW-1:0]     fp_inc;
	logic              full;
	logic              empty;

	logic              we;
	logic [PW-1:0]     waddr;
	logic [PW-1:0]     raddr;
	logic              rd_sel;
	logic [STAT_W-1:0] stat;
	logic [PW-1:0]     fp_nxt;
	logic [CAP_W-1:0]  cnt_nxt;

	// Clamp capacity to 1..DEPTH
	always_comb begin
		cap_eff = cap_q;
		if (cap_q == '0) begin
			cap_eff = CAP_W'(1);
		end else if ({{(SW-CAP_W){1'b0}}, cap_q} > SW'(DEPTH)) begin
			cap_eff = CAP_W'(DEPTH);
		end
	end

	assign cap_w = {{(SW-CAP_W){1'b0}}, cap_eff};
	assign fp_w  = {{(SW-PW){1'b0}}, fp_q};
	assign full  = (cnt_q >= cap_eff);
	assign empty = (cnt_q == '0);

	// Offset from the front: count for a back push, count-1 for the back item
	assign offs   = (in_item.op == OP_PUSH_BACK) ? cnt_q : (cnt_q - CAP_W'(1));
	assign sum_w  = fp_w + {{(SW-CAP_W){1'b0}}, offs};
	assign slot_w = (sum_w >= cap_w) ? (sum_w - cap_w) : sum_w;
	assign slot_ptr = slot_w[PW-1:0];

	assign fp_inc_w = fp_w + SW'(1);
	assign fp_inc   = (fp_inc_w == cap_w) ? '0 : fp_inc_w[PW-1:0];
	assign fp_dec   = (fp_q == '0) ? PW'(cap_eff - CAP_W'(1)) : (fp_q - PW'(1));

	always_comb begin
		we      = 1'b0;
		waddr   = slot_ptr;
		raddr   = fp_q;
		rd_sel  = 1'b0;
		stat    = ST_OK;
		fp_nxt  = fp_q;
		cnt_nxt = cnt_q;
		case (in_item.op)
			OP_PUSH_FRONT: begin
				if (full) begin
					stat = ST_FULL;
				end else begin
					we      = 1'b1;
					waddr   = fp_dec;
					fp_nxt  = fp_dec;
					cnt_nxt = cnt_q + CAP_W'(1);
				end
			end
			OP_PUSH_BACK: begin
				if (full) begin
					stat = ST_FULL;
				end else begin
					we      = 1'b1;
					cnt_nxt = cnt_q + CAP_W'(1);
				end
			end
			OP_POP_FRONT, OP_PEEK_FRONT: begin
				if (empty) begin
					stat = ST_EMPTY;
				end else begin
					rd_sel = 1'b1;
					if (in_item.op == OP_POP_FRONT) begin
						fp_nxt  = fp_inc;
						cnt_nxt = cnt_q - CAP_W'(1);
					end
				end
			end
			OP_POP_BACK, OP_PEEK_BACK: begin
				if (empty) begin
					stat = ST_EMPTY;
				end else begin
					rd_sel = 1'b1;
					raddr  = slot_ptr;
					if (in_item.op == OP_POP_BACK) begin
						cnt_nxt = cnt_q - CAP_W'(1);
					end
				end
			end
			default: begin
				stat = ST_BAD_OP;
			end
		endcase
	end

	// Pointer, count and capacity; a capacity write empties the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fp_q  <= '0;
			cnt_q <= '0;
			cap_q <= CAP_RESET;
		end else if (cfg_we) begin
			fp_q  <= '0;
			cnt_q <= '0;
			cap_q <= cfg_wdata;
		end else if (cmd.exec) begin
			fp_q  <= fp_nxt;
			cnt_q <= cnt_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && we) begin
			mem[waddr] <= in_item.push_value;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			rdata_q   <= mem[raddr];
			rd_sel_q  <= rd_sel;
			stat_q    <= stat;
			cnt_res_q <= cnt_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q.read_value <= rd_sel_q ? rdata_q : '0;
			out_q.status     <= stat_q;
			out_q.item_count <= cnt_res_q;
		end
	end

	assign out_item = out_q;

	a_count_in_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= cap_eff)
		else $error("rbd_dpath: item count above capacity");

	a_front_in_cap: assert property (@(posedge clk) disable iff (!arst_n)
		fp_w < cap_w)
		else $error("rbd_dpath: front pointer outside capacity");

	a_full_push_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && !cfg_we && full
			&& (in_item.op == OP_PUSH_FRONT || in_item.op == OP_PUSH_BACK))
		|=> (cnt_q == $past(cnt_q)) && (fp_q == $past(fp_q)))
		else $error("rbd_dpath: dropped push changed state");

endmodule : rbd_dpath

`default_nettype wire

// ===== sim/deque_checker.sv =====
// ----------------------------------------------------------------------------
// deque_checker: result predictor and scoreboard for ring_buffer_deque
// Tracks its own copy of the deque, queues the expected result of every
// accepted item and compares each delivered result field by field.
// ----------------------------------------------------------------------------

module deque_checker
	import rbd_pkg::*;
#(
	parameter int unsigned DEPTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_ready,
	input  in_item_t         in_item,
	input  logic             out_valid,
	input  logic             out_ready,
	input  out_item_t        out_item,
	input  logic             cfg_we,
	input  logic [CAP_W-1:0] cfg_wdata,
	output int               fail_count,
	output int               pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PRINT_LIMIT = 50;

	logic signed [DATA_W-1:0] slot_data [DEPTH];
	int unsigned              head_idx;
	int unsigned              held;
	logic [CAP_W-1:0]         cap_reg;
	out_item_t                expected_q [$];

	task automatic report_mismatch(input string what);
		fail_count++;
		if (fail_count <= PRINT_LIMIT)
			$display("%0t mismatch: %s", $time, what);
	endtask

	// Register value clamped to 1..DEPTH
	function automatic int unsigned cap_limit();
		int unsigned c;
		c = cap_reg;
		if (c == 0) c = 1;
		if (c > DEPTH) c = DEPTH;
		return c;
	endfunction

	// Run one operation on the shadow deque and return its result
	function automatic out_item_t deque_apply(input in_item_t it);
		int unsigned cap;
		int unsigned pos;
		out_item_t   r;
		cap = cap_limit();
		r.read_value = '0;
		r.status = ST_OK;
		case (it.op)
			OP_PUSH_FRONT, OP_PUSH_BACK: begin
				if (held >= cap) begin
					r.status = ST_FULL;
				end else begin
					if (it.op == OP_PUSH_FRONT) begin
						head_idx = (head_idx + cap - 1) % cap;
						pos = head_idx;
					end else begin
						pos = (head_idx + held) % cap;
					end
					slot_data[pos] = it.push_value;
					held++;
				end
			end
			OP_POP_FRONT, OP_PEEK_FRONT: begin
				if (held == 0) begin
					r.status = ST_EMPTY;
				end else begin
					r.read_value = slot_data[head_idx];
					if (it.op == OP_POP_FRONT) begin
						head_idx = (head_idx + 1) % cap;
						held--;
					end
				end
			end
			OP_POP_BACK, OP_PEEK_BACK: begin
				if (held == 0) begin
					r.status = ST_EMPTY;
				end else begin
					r.read_value = slot_data[(head_idx + held - 1) % cap];
					if (it.op == OP_POP_BACK) held--;
				end
			end
			default: begin
				r.status = ST_BAD_OP;
			end
		endcase
		r.item_count = CAP_W'(held);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			expected_q.delete();
			head_idx = 0;
			held = 0;
			cap_reg = CAP_RESET;
			pending = 0;
			fail_count = 0;
		end else begin
			// Retire first: a result never belongs to an item taken at the same edge
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					report_mismatch($sformatf("result with nothing expected (status %0d)",
						out_item.status));
				end else begin
					want = expected_q.pop_front();
					if (out_item.read_value !== want.read_value)
						report_mismatch($sformatf("read_value expected %0d, got %0d",
							want.read_value, out_item.read_value));
					if (out_item.status !== want.status)
						report_mismatch($sformatf("status expected %0d, got %0d",
							want.status, out_item.status));
					if (out_item.item_count !== want.item_count)
						report_mismatch($sformatf("item_count expected %0d, got %0d",
							want.item_count, out_item.item_count));
				end
			end
			if (cfg_we) begin
				cap_reg = cfg_wdata;
				head_idx = 0;
				held = 0;
			end
			if (in_valid && in_ready)
				expected_q.push_back(deque_apply(in_item));
			pending = expected_q.size();
		end
	end

endmodule : deque_checker

// ===== sim/tb_ring_buffer_deque.sv =====
// ----------------------------------------------------------------------------
// tb_ring_buffer_deque: testbench for the ring buffer deque
// Directed corner items, then capacity phases of random traffic with bursty
// input, a stalling output and one long hold-off; deque_checker scores it.
// ----------------------------------------------------------------------------

module tb_ring_buffer_deque;
	timeunit 1ns;
	timeprecision 1ps;

	import rbd_pkg::*;

	localparam time HALF_PERIOD = 5ns;
	localparam int  RESET_CYCLES = 6;
	localparam int  STALL_LIMIT = 2000;   // cycles with no item moving on either side
	localparam int  SETTLE_CYCLES = 4;    // the block takes each item through an accept and a response state
	localparam int  HOLDOFF_CYCLES = 80;
	localparam int  PHASE_ITEMS = 50;
	localparam int  NUM_PHASES = 14;

	// Op codes the block does not define
	localparam logic [OP_W-1:0] OP_UNUSED_6 = 3'd6;
	localparam logic [OP_W-1:0] OP_UNUSED_7 = 3'd7;

	// Traffic mixes
	localparam int MIX_BALANCED = 0;
	localparam int MIX_PUSHES   = 1;
	localparam int MIX_POPS     = 2;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             in_valid;
	logic             in_ready;
	in_item_t         in_item;
	logic             out_valid;
	logic             out_ready;
	out_item_t        out_item;
	logic             cfg_we;
	logic [CAP_W-1:0] cfg_wdata;

	int fail_count;
	int pending;
	int holdoff_left = 0;
	int idle_cycles = 0;

	always #HALF_PERIOD clk = ~clk;

	ring_buffer_deque #(
		.DEPTH(16)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	deque_checker #(
		.DEPTH(16)
	) i_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.fail_count(fail_count),
		.pending   (pending)
	);

	// Watchdog: end the run if nothing moves for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Receiver: stretches of always-ready, coin-flip and mostly-ready behavior.
	// A hold-off request overrides the pattern and is counted down here.
	initial begin
		int mode;
		int span;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			mode = $urandom_range(0, 2);
			span = $urandom_range(8, 60);
			repeat (span) begin
				@(negedge clk);
				if (holdoff_left > 0) begin
					out_ready = 1'b0;
					holdoff_left--;
				end else begin
					case (mode)
						0: out_ready = 1'b1;
						1: out_ready = $urandom_range(0, 1);
						default: out_ready = ($urandom_range(0, 4) != 0);
					endcase
				end
			end
		end
	end

	// Offer one item at a falling edge and hold it until it is taken; return
	// at the next falling edge with valid still high.
	task automatic offer_item(input logic [OP_W-1:0] op, input logic signed [DATA_W-1:0] v);
		in_item.op = op;
		in_item.push_value = v;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	// Drop valid and wait until every expected result has come back
	task automatic drain();
		in_valid = 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	// Write the capacity only with the block idle
	task automatic set_capacity(input logic [CAP_W-1:0] value);
		drain();
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_wdata = value;
		cfg_we = 1'b1;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	function automatic logic signed [DATA_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2: return '0;
			3: return '1;
			default: return $urandom;
		endcase
	endfunction

	// Draw an op from the mix; a few percent are undefined codes
	function automatic logic [OP_W-1:0] pick_op(input int mix);
		int r;
		int push_pct;
		r = $urandom_range(0, 99);
		push_pct = (mix == MIX_PUSHES) ? 70 : (mix == MIX_POPS) ? 30 : 50;
		if (r < 3)
			return $urandom_range(0, 1) ? OP_UNUSED_6 : OP_UNUSED_7;
		if (r < 3 + push_pct)
			return $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
		case ($urandom_range(0, 3))
			0: return OP_POP_FRONT;
			1: return OP_POP_BACK;
			2: return OP_PEEK_FRONT;
			default: return OP_PEEK_BACK;
		endcase
	endfunction

	// Random traffic in bursts; gaps are skipped when no_gaps is set
	task automatic run_traffic(input int count, input int mix, input bit no_gaps);
		int left;
		int burst;
		int gap;
		left = count;
		while (left > 0) begin
			burst = $urandom_range(1, 12);
			if (burst > left) burst = left;
			repeat (burst) begin
				offer_item(pick_op(mix), pick_value());
				left--;
			end
			if (!no_gaps) begin
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				if (gap > 0) begin
					in_valid = 1'b0;
					repeat (gap) @(negedge clk);
				end
			end
		end
	endtask

	initial begin
		logic [CAP_W-1:0] cap_plan [NUM_PHASES];
		cap_plan = '{5'd1, 5'd2, 5'd16, 5'd31, 5'd3, 5'd0, 5'd17, 5'd7,
			5'd15, 5'd4, 5'd16, 5'd0, 5'd0, 5'd0};
		for (int i = 11; i < NUM_PHASES; i++)
			cap_plan[i] = $urandom_range(0, 31);

		// Drive every input from time zero and hold reset
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Empty deque at reset capacity: every read side op must report empty
		offer_item(OP_POP_FRONT, pick_value());
		offer_item(OP_POP_BACK, pick_value());
		offer_item(OP_PEEK_FRONT, pick_value());
		offer_item(OP_PEEK_BACK, pick_value());
		// Undefined codes leave the state alone
		offer_item(OP_UNUSED_6, 32'sh1234_5678);
		offer_item(OP_UNUSED_7, '1);
		// Extreme values at both ends, front push wraps below slot zero
		offer_item(OP_PUSH_FRONT, 32'sh7FFF_FFFF);
		offer_item(OP_PUSH_BACK, 32'sh8000_0000);
		offer_item(OP_PUSH_FRONT, '1);
		offer_item(OP_PUSH_BACK, '0);
		offer_item(OP_PEEK_FRONT, '0);
		offer_item(OP_PEEK_BACK, '0);
		offer_item(OP_POP_BACK, '0);
		offer_item(OP_POP_FRONT, '0);
		offer_item(OP_POP_FRONT, '0);
		offer_item(OP_POP_BACK, '0);

		// Capacity zero acts as one: second push is full
		set_capacity(5'd0);
		offer_item(OP_PUSH_BACK, 32'sh0000_0005);
		offer_item(OP_PUSH_FRONT, 32'sh0000_0006);
		offer_item(OP_PEEK_BACK, '0);
		offer_item(OP_POP_FRONT, '0);
		offer_item(OP_POP_BACK, '0);

		// Random phases, each behind a fresh capacity write; items still held at
		// the end of a phase are flushed by the next write
		for (int i = 0; i < NUM_PHASES; i++) begin
			set_capacity(cap_plan[i]);
			if (i == 2) begin
				// Block the receiver and keep pushing so the input stalls,
				// then pause the sender until every result is back
				holdoff_left = HOLDOFF_CYCLES;
				run_traffic(PHASE_ITEMS / 2, MIX_PUSHES, 1'b1);
				drain();
				run_traffic(PHASE_ITEMS / 2, MIX_POPS, 1'b0);
			end else begin
				run_traffic(PHASE_ITEMS, i % 3, (i % 4) == 1);
			end
		end

		// Wait for the last results, then let the pipeline settle
		drain();
		repeat (SETTLE_CYCLES * 2) @(negedge clk);

		if (fail_count == 0 && pending == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule : tb_ring_buffer_deque

// ===== sim.f =====
sv/rbd_pkg.sv
sv/rbd_ctrl.sv
sv/rbd_dpath.sv
sv/ring_buffer_deque.sv
sim/deque_checker.sv
sim/tb_ring_buffer_deque.sv
